[rtl/vpa_pkg.sv]
// Package for the variable partition allocator: constants, payload structs, FSM states.
// No dependencies.
`default_nettype none
package vpa_pkg;
  localparam int MaxSegments = 32;
  localparam int AddrBits    = 16;
  localparam int IdxBits     = $clog2(MaxSegments);
  localparam int CntBits     = $clog2(MaxSegments + 1);
  localparam int SizeBits    = AddrBits + 1;

  localparam logic [1:0] StatOk   = 2'd0;
  localparam logic [1:0] StatNoFit = 2'd1;
  localparam logic [1:0] StatFull = 2'd2;

  localparam logic [1:0] FitFirst = 2'd0;
  localparam logic [1:0] FitBest  = 2'd1;
  localparam logic [1:0] FitWorst = 2'd2;

  localparam logic OpAlloc = 1'b0;
  localparam logic OpFree  = 1'b1;

  localparam logic [1:0] RegTotal = 2'd0;
  localparam logic [1:0] RegFit   = 2'd1;
  localparam logic [1:0] RegSlack = 2'd2;

  typedef struct packed {
    logic        opcode;
    logic [16:0] req_size;
    logic [15:0] block_start;
  } in_item_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [15:0] grant_start;
    logic [16:0] grant_size;
    logic [5:0]  free_count;
  } out_item_t;

  typedef struct packed {
    logic [AddrBits-1:0] start;
    logic [SizeBits-1:0] size;
  } seg_t;

  typedef enum logic [3:0] {
    S_IDLE, S_ASCAN, S_AWAIT, S_AWRITE, S_REMOVE,
    S_FCOUNT, S_FSCAN, S_FWRITE, S_DONE
  } state_t;
endpackage
`default_nettype wire

[rtl/vpa_seg_ram.sv]
// Segment table memory: one write port, one registered read port.
// Depends on vpa_pkg.
`default_nettype none
module vpa_seg_ram (
  input  wire logic                   clk,
  input  wire logic                   we,
  input  wire logic [vpa_pkg::IdxBits-1:0] waddr,
  input  wire vpa_pkg::seg_t          wdata,
  input  wire logic [vpa_pkg::IdxBits-1:0] raddr,
  output vpa_pkg::seg_t               rdata
);
  import vpa_pkg::*;
  seg_t mem [MaxSegments];
  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end
endmodule
`default_nettype wire

[rtl/variable_partition_allocator.sv]
// Variable partition allocator top level: APB registers, sequencer, segment RAM.
// Depends on vpa_pkg and vpa_seg_ram.
// Sequence from input accept to out_valid: allocate scans the free segments,
// then closes the gap when a whole segment is granted; free makes a count pass
// and then a write-back pass, stops after the count pass on table overflow, and skips both for a zero-size free.
// One item in flight; a new item is accepted only once the result has been taken.
// Reset: registers 1024/0/10; entry 0 is written as [0,1024) while rst is held.
`default_nettype none
module variable_partition_allocator (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               in_valid,
  output logic                    in_ready,
  input  wire vpa_pkg::in_item_t  in_item,
  output logic                    out_valid,
  input  wire logic               out_ready,
  output vpa_pkg::out_item_t      out_item,
  input  wire logic               psel,
  input  wire logic               penable,
  input  wire logic               pwrite,
  input  wire logic [3:0]         paddr,
  input  wire logic [31:0]        pwdata,
  output logic [31:0]             prdata,
  output logic                    pready
);
  import vpa_pkg::*;

  localparam logic [SizeBits-1:0] Span = SizeBits'(1) << AddrBits;
  localparam logic [16:0] DefaultTotal = 17'd1024;

  // configuration
  logic [16:0] total_size;
  logic [1:0]  fit_policy;
  logic [15:0] slack_limit;
  logic        cfg_wr;
  logic [1:0]  cfg_idx;
  assign pready  = 1'b1;
  assign cfg_idx = paddr[3:2];
  assign cfg_wr  = psel && penable && pwrite;

  always_comb begin
    case (cfg_idx)
      RegTotal: prdata = {15'd0, total_size};
      RegFit:   prdata = {30'd0, fit_policy};
      RegSlack: prdata = {16'd0, slack_limit};
      default:  prdata = 32'd0;
    endcase
  end

  // sequencer registers
  state_t state, state_next;
  logic [CntBits-1:0] count;        // number of valid segments
  in_item_t req;
  logic [CntBits-1:0] idx;          // scan read index
  logic [CntBits-1:0] pos;          // index of data in rdata
  logic               rd_live;      // rdata holds entry pos
  logic               found;
  logic [IdxBits-1:0] pick;
  seg_t               pick_seg;
  out_item_t          res;
  // free merge state
  logic [AddrBits-1:0] fstart;
  logic [SizeBits-1:0] fsize;
  logic                placed;
  logic [CntBits:0]    mcount;      // merged output count
  seg_t                acc;         // pending merged segment
  logic                acc_v;
  logic [CntBits-1:0]  widx;
  logic                counting;    // free first pass (dry run)

  // RAM
  logic               we;
  logic [IdxBits-1:0] waddr, raddr;
  seg_t               wdata, rdata;
  vpa_seg_ram u_ram (.clk, .we, .waddr, .wdata, .raddr, .rdata);

  assign in_ready  = (state == S_IDLE);
  assign out_valid = (state == S_DONE);
  assign out_item  = res;

  // candidate for the free merge stream: next element in address order.
  // The released block goes in before the first entry that starts above it,
  // or at the end once every entry has been read.
  seg_t nxt;
  logic nxt_v, take_new, sp_end, scan_end, full_hit;
  logic [SizeBits-1:0] acc_end;
  always_comb begin
    take_new = 1'b0;
    nxt_v = 1'b0;
    nxt = '0;
    if (!placed && (rd_live ? (rdata.start > fstart) : (idx >= count))) begin
      take_new = 1'b1;
      nxt_v = 1'b1;
      nxt.start = fstart;
      nxt.size  = fsize;
    end else if (rd_live) begin
      nxt_v = 1'b1;
      nxt = rdata;
    end
    acc_end  = SizeBits'(acc.start) + acc.size;
    sp_end   = acc_v && (acc_end == SizeBits'(nxt.start));
    scan_end = !nxt_v && (idx >= count) && !rd_live;
    full_hit = mcount > (CntBits+1)'(MaxSegments);
  end

  logic [SizeBits-1:0] fsz_cut, span_room, left;
  always_comb begin
    span_room = Span - SizeBits'(in_item.block_start);
    fsz_cut   = (in_item.req_size > span_room) ? span_room : in_item.req_size;
    left      = pick_seg.size - req.req_size;
  end

  always_comb begin
    state_next = state;
    case (state)
      S_IDLE:   if (in_valid) state_next = (in_item.opcode == OpAlloc) ? S_ASCAN : S_FCOUNT;
      S_ASCAN:  if (!rd_live && idx >= count) state_next = S_AWAIT;
      S_AWAIT:  state_next = S_AWRITE;
      S_AWRITE: begin
        // whole-segment grant closes the gap before the result goes out
        if (found && left <= SizeBits'(slack_limit)) state_next = S_REMOVE;
        else state_next = S_DONE;
      end
      S_REMOVE: if (idx >= count) state_next = S_DONE;
      S_FCOUNT: state_next = (fsize != '0) ? S_FSCAN : S_DONE;
      S_FSCAN: begin
        if (scan_end) begin
          if (!counting) state_next = S_FWRITE;
          else if (full_hit) state_next = S_DONE;
        end
      end
      S_FWRITE: state_next = S_DONE;
      S_DONE:   if (out_ready) state_next = S_IDLE;
      default:  state_next = S_IDLE;
    endcase
  end

  always_comb begin
    we = 1'b0;
    waddr = widx[IdxBits-1:0];
    wdata = acc;
    // re-read the held entry when the released block is slotted in ahead of it
    raddr = (state == S_FSCAN && take_new && rd_live) ? pos[IdxBits-1:0] : idx[IdxBits-1:0];
    if (rst) begin
      we = 1'b1;
      waddr = '0;
      wdata.start = '0;
      wdata.size = DefaultTotal;
    end else if (cfg_wr && cfg_idx == RegTotal) begin
      we = 1'b1;
      waddr = '0;
      wdata.start = '0;
      wdata.size = (pwdata[16:0] > Span) ? Span : pwdata[16:0];
    end else if (state == S_AWRITE && found && left > SizeBits'(slack_limit)) begin
      we = 1'b1;
      waddr = pick;
      wdata.start = pick_seg.start + req.req_size[AddrBits-1:0];
      wdata.size = left;
    end else if (state == S_REMOVE && rd_live) begin
      we = 1'b1;
      waddr = pos[IdxBits-1:0] - 1'b1;
      wdata = rdata;
    end else if (state == S_FSCAN && !counting && nxt_v && !sp_end && acc_v) begin
      we = 1'b1;
      wdata = acc;
    end else if (state == S_FWRITE && acc_v) begin
      we = 1'b1;
      wdata = acc;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      total_size <= DefaultTotal;
      fit_policy <= FitFirst;
      slack_limit <= 16'd10;
      count <= CntBits'(1);
      rd_live <= 1'b0;
      idx <= '0;
    end else begin
      state <= state_next;
      if (cfg_wr) begin
        case (cfg_idx)
          RegTotal: begin
            total_size <= pwdata[16:0];
            count <= (pwdata[16:0] == 17'd0) ? '0 : CntBits'(1);
          end
          RegFit:   fit_policy <= pwdata[1:0];
          RegSlack: slack_limit <= pwdata[15:0];
          default: ;
        endcase
      end
      case (state)
        S_IDLE: if (in_valid) begin
          req <= in_item;
          fstart <= in_item.block_start;
          fsize <= fsz_cut;
          idx <= '0;
          rd_live <= 1'b0;
          found <= 1'b0;
          placed <= 1'b0;
          acc_v <= 1'b0;
          mcount <= '0;
          widx <= '0;
          counting <= 1'b1;
          res <= '0;
        end
        S_ASCAN: begin
          rd_live <= (idx < count);
          pos <= idx;
          if (idx < count) idx <= idx + 1'b1;
          if (rd_live && rdata.size >= req.req_size && req.req_size != '0) begin
            if (!found ||
                (fit_policy == FitBest && rdata.size < pick_seg.size) ||
                (fit_policy == FitWorst && rdata.size > pick_seg.size)) begin
              if (!found || fit_policy == FitBest || fit_policy == FitWorst) begin
                found <= 1'b1;
                pick <= pos[IdxBits-1:0];
                pick_seg <= rdata;
              end
            end
          end
        end
        S_AWAIT: ;
        S_AWRITE: begin
          if (!found) begin
            res.status <= StatNoFit;
            res.free_count <= 6'(count);
          end else begin
            res.status <= StatOk;
            res.grant_start <= pick_seg.start;
            if (left <= SizeBits'(slack_limit)) begin
              res.grant_size <= pick_seg.size;
              res.free_count <= 6'(count - 1'b1);
              idx <= CntBits'(pick) + 1'b1;
              rd_live <= 1'b0;
            end else begin
              res.grant_size <= req.req_size;
              res.free_count <= 6'(count);
            end
          end
        end
        S_REMOVE: begin
          rd_live <= (idx < count);
          pos <= idx;
          if (idx < count) idx <= idx + 1'b1;
          else count <= count - 1'b1;
        end
        S_FCOUNT: begin
          // zero-size free: done immediately with table untouched
          res.free_count <= 6'(count);
        end
        S_FSCAN: begin
          // entry in rdata stays put while the released block is taken
          if (!(take_new && rd_live)) begin
            rd_live <= (idx < count);
            pos <= idx;
            if (idx < count) idx <= idx + 1'b1;
          end
          if (take_new) placed <= 1'b1;
          if (nxt_v) begin
            if (sp_end) acc.size <= acc.size + nxt.size;
            else begin
              acc <= nxt;
              acc_v <= 1'b1;
              mcount <= mcount + 1'b1;
              if (acc_v && !counting) widx <= widx + 1'b1;
            end
          end
          if (scan_end && counting) begin
            if (full_hit) begin
              res.status <= StatFull;
            end else begin
              counting <= 1'b0;
              idx <= '0;
              placed <= 1'b0;
              acc_v <= 1'b0;
              mcount <= '0;
              widx <= '0;
            end
          end
        end
        S_FWRITE: begin
          count <= mcount[CntBits-1:0];
          res.free_count <= 6'(mcount);
          res.status <= StatOk;
        end
        default: ;
      endcase
    end
  end

  assert property (@(posedge clk) disable iff (rst) count <= CntBits'(MaxSegments))
    else $error("segment count overflow");
  assert property (@(posedge clk) disable iff (rst) out_valid |-> !in_ready)
    else $error("accept while result pending");
  assert property (@(posedge clk) disable iff (rst)
    (out_valid && res.status != StatOk) |-> (res.grant_size == '0))
    else $error("grant on failure");
endmodule
`default_nettype wire

[sim/variable_partition_allocator_test.sv]
// Self-checking testbench for variable_partition_allocator: directed and random
// allocate/free items, APB register phases, with a built-in model of the free list.
// Depends on vpa_pkg and the allocator RTL.
`timescale 1ns / 100ps
module variable_partition_allocator_test;
  import vpa_pkg::*;

  localparam int MemSpan = 1 << AddrBits;
  localparam logic [1:0] FitUnused = 2'd3;
  localparam int DrainCycles = 100;   // drain wait, sized to cover a worst-case free
  localparam int LongHold = 400;      // receiver hold-off that backs up the input

  logic clk;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_ready;
  in_item_t in_item = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  out_item_t out_item;
  logic psel = 1'b0;
  logic penable = 1'b0;
  logic pwrite = 1'b0;
  logic [3:0] paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic pready;

  variable_partition_allocator dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready), .in_item(in_item),
    .out_valid(out_valid), .out_ready(out_ready), .out_item(out_item),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Shared bookkeeping.
  in_item_t pending_items[$];
  out_item_t expected_results[$];
  int granted_lo[$];           // blocks handed out, candidates for well-formed frees
  int granted_len[$];
  bit quiet = 0;               // no idling in the final phase
  int hold_req = 0;            // bumped by the sequencer to ask for a long receiver stall
  int failures = 0;
  int n_items = 0, n_ok = 0, n_nofit = 0, n_full = 0;

  // Allocator model: register copies and free list in address order.
  int cfg_total, cfg_slack;
  logic [1:0] cfg_fit;
  int seg_lo[MaxSegments];
  int seg_len[MaxSegments];
  int seg_count;

  function automatic void rebuild_table();
    int span;
    span = (cfg_total > MemSpan) ? MemSpan : cfg_total;
    seg_count = 0;
    if (span != 0) begin
      seg_lo[0] = 0;
      seg_len[0] = span;
      seg_count = 1;
    end
  endfunction

  function automatic logic [1:0] carve_block(int req, output int glo, output int glen);
    int pick;
    bit found;
    pick = 0;
    found = 0;
    glo = 0;
    glen = 0;
    if (req == 0) return StatNoFit;
    for (int i = 0; i < seg_count; i++) begin
      if (seg_len[i] < req) continue;
      if (!found) begin
        pick = i;
        found = 1;
        if (cfg_fit != FitBest && cfg_fit != FitWorst) break;
      end else if (cfg_fit == FitBest && seg_len[i] < seg_len[pick]) begin
        pick = i;
      end else if (cfg_fit == FitWorst && seg_len[i] > seg_len[pick]) begin
        pick = i;
      end
    end
    if (!found) return StatNoFit;
    glo = seg_lo[pick];
    if (seg_len[pick] - req <= cfg_slack) begin
      // leftover within slack: hand out the whole segment and close the gap
      glen = seg_len[pick];
      for (int i = pick; i + 1 < seg_count; i++) begin
        seg_lo[i] = seg_lo[i + 1];
        seg_len[i] = seg_len[i + 1];
      end
      seg_count--;
    end else begin
      glen = req;
      seg_lo[pick] += req;
      seg_len[pick] -= req;
    end
    return StatOk;
  endfunction

  function automatic logic [1:0] release_block(int lo, int len);
    int ts[MaxSegments + 1];
    int tz[MaxSegments + 1];
    int ms[MaxSegments + 1];
    int mz[MaxSegments + 1];
    int n, m;
    bit placed;
    n = 0;
    m = 0;
    placed = 0;
    if (len > MemSpan - lo) len = MemSpan - lo;
    if (len == 0) return StatOk;
    for (int i = 0; i < seg_count; i++) begin
      if (!placed && seg_lo[i] > lo) begin
        ts[n] = lo; tz[n] = len; n++;
        placed = 1;
      end
      ts[n] = seg_lo[i]; tz[n] = seg_len[i]; n++;
    end
    if (!placed) begin
      ts[n] = lo; tz[n] = len; n++;
    end
    // only exactly adjacent neighbors merge
    for (int i = 0; i < n; i++) begin
      if (m > 0 && ms[m - 1] + mz[m - 1] == ts[i]) begin
        mz[m - 1] += tz[i];
      end else begin
        ms[m] = ts[i]; mz[m] = tz[i]; m++;
      end
    end
    if (m > MaxSegments) return StatFull;
    for (int i = 0; i < m; i++) begin
      seg_lo[i] = ms[i];
      seg_len[i] = mz[i];
    end
    seg_count = m;
    return StatOk;
  endfunction

  function automatic out_item_t predict_result(in_item_t it);
    out_item_t r;
    int glo, glen;
    r = '0;
    glo = 0;
    glen = 0;
    if (it.opcode == OpAlloc) begin
      r.status = carve_block(int'(it.req_size), glo, glen);
      if (r.status == StatOk) begin
        r.grant_start = glo[15:0];
        r.grant_size = glen[16:0];
        granted_lo.push_back(glo);
        granted_len.push_back(glen);
      end
    end else begin
      r.status = release_block(int'(it.block_start), int'(it.req_size));
    end
    r.free_count = seg_count[5:0];
    return r;
  endfunction

  // Driver: offers pending items, random bursts of idle cycles between them.
  int send_gap = 0;
  always @(posedge clk) begin
    logic next_valid;
    in_item_t next_item;
    next_valid = in_valid;
    next_item = in_item;
    if (rst) begin
      next_valid = 1'b0;
    end else begin
      if (in_valid && in_ready) begin
        expected_results.push_back(predict_result(in_item));
        n_items++;
        next_valid = 1'b0;
      end
      if (next_valid) begin
        // still waiting for acceptance: hold item
      end else if (send_gap > 0) begin
        send_gap--;
      end else if (pending_items.size() > 0) begin
        if (!quiet && $urandom_range(0, 7) == 0) begin
          send_gap = $urandom_range(1, 9);
        end else begin
          next_item = pending_items.pop_front();
          next_valid = 1'b1;
        end
      end
    end
    in_valid <= next_valid;
    in_item <= next_item;
  end

  // Monitor: random stall bursts, one long hold-off on request, result check.
  int recv_stall = 0;
  int hold_seen = 0;
  always @(posedge clk) begin
    logic next_ready;
    out_item_t exp_r;
    next_ready = 1'b1;
    if (!rst && out_valid && out_ready) begin
      case (out_item.status)
        StatOk:    n_ok++;
        StatNoFit: n_nofit++;
        StatFull:  n_full++;
        default: ;
      endcase
      if (expected_results.size() == 0) begin
        $error("unexpected result item: %p", out_item);
        failures++;
      end else begin
        exp_r = expected_results.pop_front();
        if (out_item.status !== exp_r.status) begin
          $error("status: expected %0d, got %0d", exp_r.status, out_item.status);
          failures++;
        end
        if (out_item.grant_start !== exp_r.grant_start) begin
          $error("grant_start: expected %0d, got %0d", exp_r.grant_start,
                 out_item.grant_start);
          failures++;
        end
        if (out_item.grant_size !== exp_r.grant_size) begin
          $error("grant_size: expected %0d, got %0d", exp_r.grant_size,
                 out_item.grant_size);
          failures++;
        end
        if (out_item.free_count !== exp_r.free_count) begin
          $error("free_count: expected %0d, got %0d", exp_r.free_count,
                 out_item.free_count);
          failures++;
        end
      end
    end
    if (rst) begin
      next_ready = 1'b0;
    end else if (recv_stall > 0) begin
      recv_stall--;
      next_ready = 1'b0;
    end else if (hold_req != hold_seen) begin
      hold_seen = hold_req;
      recv_stall = LongHold;
      next_ready = 1'b0;
    end else if (!quiet && $urandom_range(0, 7) == 0) begin
      recv_stall = $urandom_range(1, 9) - 1;
      next_ready = 1'b0;
    end
    out_ready <= next_ready;
  end

  // Sequencer tasks.
  task automatic wait_idle();
    while (pending_items.size() > 0 || in_valid || expected_results.size() > 0)
      @(posedge clk);
    repeat (DrainCycles) @(posedge clk);
  endtask

  task automatic apb_write(logic [1:0] idx, logic [31:0] data);
    @(posedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= data;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    // register is written at this edge
    case (idx)
      RegTotal: begin
        cfg_total = int'(data[16:0]);
        rebuild_table();
        granted_lo.delete();
        granted_len.delete();
      end
      RegFit:   cfg_fit = data[1:0];
      RegSlack: cfg_slack = int'(data[15:0]);
      default: ;
    endcase
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
  endtask

  task automatic set_config(logic [31:0] total, logic [31:0] fit, logic [31:0] slack);
    wait_idle();
    apb_write(RegTotal, total);
    apb_write(RegFit, fit);
    apb_write(RegSlack, slack);
  endtask

  task automatic send(logic op, int size, int lo);
    in_item_t it;
    it.opcode = op;
    it.req_size = size[16:0];
    it.block_start = lo[15:0];
    while (pending_items.size() >= 2) @(posedge clk);
    pending_items.push_back(it);
  endtask

  // Mostly allocs and frees of granted blocks; the rest is noise.
  task automatic send_random();
    int r, k, top;
    r = $urandom_range(0, 99);
    top = (cfg_total / 16 > 2) ? cfg_total / 16 : 2;
    if (r < 50) begin
      if ($urandom_range(0, 9) != 0) send(OpAlloc, $urandom_range(1, top), $urandom);
      else case ($urandom_range(0, 3))
        0: send(OpAlloc, 0, $urandom);
        1: send(OpAlloc, MemSpan, $urandom);
        2: send(OpAlloc, cfg_total, $urandom);
        default: send(OpAlloc, $urandom_range(0, 17'h1FFFF), $urandom);
      endcase
    end else if (r < 88 && granted_lo.size() > 0) begin
      k = $urandom_range(0, granted_lo.size() - 1);
      send(OpFree, granted_len[k], granted_lo[k]);
      granted_lo.delete(k);
      granted_len.delete(k);
    end else begin
      case ($urandom_range(0, 2))
        0: send(OpFree, $urandom_range(0, 17'h1FFFF), $urandom_range(0, 16'hFFFF));
        1: send(OpFree, 0, $urandom_range(0, 16'hFFFF));
        default: send(OpFree, $urandom_range(1, 64), $urandom_range(0, 16'hFFFF));
      endcase
    end
  endtask

  initial begin
    int k;
    cfg_total = 1024;
    cfg_fit = FitFirst;
    cfg_slack = 10;
    rebuild_table();
    repeat (9) @(posedge clk);
    rst <= 1'b0;

    // Directed: reset state, zero sizes, overflow, overlap, edges.
    send(OpAlloc, 0, 16'hFFFF);          // zero-size allocate fails
    send(OpAlloc, 100, 0);
    send(OpAlloc, 1024, 0);              // no longer fits
    send(OpFree, 0, 0);                  // zero-size free
    send(OpFree, 100, 0);                // merges back to one segment
    send(OpAlloc, 17'h10000, 0);
    send(OpFree, 100, 16'hFFF6);         // past memory end, clipped
    send(OpFree, 10, 50);                // overlapping release
    send(OpAlloc, 1020, 0);              // within slack, whole segment
    set_config(1024, FitUnused, 0);      // unused policy acts as first fit
    send(OpAlloc, 1, 0);
    send(OpAlloc, 1023, 0);
    send(OpAlloc, 1, 0);                 // empty table
    set_config(0, FitBest, 16'hFFFF);    // empty memory
    send(OpAlloc, 1, 0);
    send(OpFree, 5, 5);
    send(OpAlloc, 1, 0);
    set_config(17'h1FFFF, FitWorst, 0);  // saturates to full span
    send(OpAlloc, MemSpan, 0);
    send(OpFree, 17'h1FFFF, 0);
    send(OpAlloc, 1, 0);

    // Fragmentation until the free table overflows.
    set_config(1024, FitFirst, 0);
    for (int i = 0; i < 80; i++) send(OpAlloc, $urandom_range(1, 8), $urandom);
    wait_idle();
    k = 0;
    for (int i = 0; i < granted_lo.size(); i += 2) begin
      send(OpFree, granted_len[i], granted_lo[i]);
      k++;
    end
    wait_idle();
    granted_lo.delete();
    granted_len.delete();

    // Random phases over several settings; the last one without idling.
    begin
      int totals[8] = '{1024, 1024, 65536, 200, 1, 4096, 131071, 2048};
      int fits[8]   = '{1, 2, 0, 1, 2, 3, 1, 0};
      int slacks[8] = '{0, 10, 65535, 3, 0, 20, 100, 5};
      for (int p = 0; p < 8; p++) begin
        set_config(totals[p], fits[p], slacks[p]);
        if (p == 7) quiet = 1;
        for (int i = 0; i < 140; i++) begin
          if (p == 1 && i == 30) hold_req++;
          send_random();
        end
      end
    end

    while (pending_items.size() > 0 || in_valid || expected_results.size() > 0)
      @(posedge clk);
    repeat (DrainCycles) @(posedge clk);
    if (expected_results.size() > 0) begin
      $error("%0d result items never arrived", expected_results.size());
      failures++;
    end
    $display("Ran %0d items over 13 register settings, one a table-overflow phase;",
             n_items);
    $display("results: %0d ok, %0d no fit, %0d table full", n_ok, n_nofit, n_full);
    if (failures == 0) begin
      $display("variable_partition_allocator verification clean");
    end else begin
      $display("variable_partition_allocator verification failed");
    end
    $finish;
  end

  initial begin
    #10ms;
    $display("variable_partition_allocator verification failed");
    $finish;
  end
endmodule
